### rtl/core/obq_pkg.sv
`default_nettype none

package obq_pkg;

    // Field and format widths
    localparam int COORD_W    = 32;
    localparam int AXIS_FRAC  = 14;
    localparam int AXIS_W     = AXIS_FRAC + 2;
    localparam int HALF_W     = COORD_W - 1;

    // Projection path
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + AXIS_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int LOC_W      = SUM_W - AXIS_FRAC;
    localparam int ERRD_W     = LOC_W + 1;

    // Distance test
    localparam int SQ_W       = 2 * HALF_W;
    localparam int D2_W       = SQ_W + 1;

    // World transform path
    localparam int WPROD_W    = COORD_W + AXIS_W;
    localparam int WSUM_W     = WPROD_W + 1;
    localparam int WLOC_W     = WSUM_W - AXIS_FRAC;
    localparam int WORLD_W    = WLOC_W + 1;

    localparam int NSTAGE     = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [SUM_W-1:0]  RND_SUM  = SUM_W'(1 << (AXIS_FRAC - 1));
    localparam logic signed [WSUM_W-1:0] RND_WSUM = WSUM_W'(1 << (AXIS_FRAC - 1));
    localparam logic [AXIS_W-1:0]        AXIS_ONE = AXIS_W'(1 << AXIS_FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_HALF_X   = 3'd2,
        REG_HALF_Y   = 3'd3,
        REG_AXIS_X   = 3'd4,
        REG_AXIS_Y   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [HALF_W-1:0]  half_x;
        logic        [HALF_W-1:0]  half_y;
        logic signed [AXIS_W-1:0]  axis_x;
        logic signed [AXIS_W-1:0]  axis_y;
    } t_cfg;

    // Per-stage load enables, stage 1 in bit 0
    typedef logic [NSTAGE-1:0] t_stage_en;

    // Hand-off from the clamp stage to the resolve stages
    typedef struct packed {
        logic signed [COORD_W-1:0] clamp_i;
        logic signed [COORD_W-1:0] clamp_j;
        logic        [HALF_W-1:0]  err_i;
        logic        [HALF_W-1:0]  err_j;
        logic        [HALF_W-1:0]  radius;
        logic                      in_box;
        logic                      far;
    } t_clamp;

endpackage

`default_nettype wire

### rtl/core/obq_cfg.sv
`default_nettype none

module obq_cfg
    import obq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [COORD_W-1:0]   i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.half_x   <= '0;
            r_cfg.half_y   <= '0;
            r_cfg.axis_x   <= AXIS_ONE;
            r_cfg.axis_y   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_CENTER_X: r_cfg.center_x <= i_cfg_wdata;
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_wdata;
                REG_HALF_X:   r_cfg.half_x   <= i_cfg_wdata[HALF_W-1:0];
                REG_HALF_Y:   r_cfg.half_y   <= i_cfg_wdata[HALF_W-1:0];
                REG_AXIS_X:   r_cfg.axis_x   <= i_cfg_wdata[AXIS_W-1:0];
                REG_AXIS_Y:   r_cfg.axis_y   <= i_cfg_wdata[AXIS_W-1:0];
                default:      ; // drop writes to unmapped indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/core/obq_proj.sv
`default_nettype none

module obq_proj
    import obq_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire t_stage_en                 i_adv,
    input  wire t_cfg                      i_cfg,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic        [HALF_W-1:0]  i_radius,
    output logic signed      [LOC_W-1:0]   o_loc_i,
    output logic signed      [LOC_W-1:0]   o_loc_j,
    output logic             [HALF_W-1:0]  o_radius
);

    // Stage 1: offset from center
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic        [HALF_W-1:0] r1_radius;
    // Stage 2: axis products
    logic signed [PROD_W-1:0] r_p_xax, r_p_yay, r_p_yax, r_p_xay;
    logic        [HALF_W-1:0] r2_radius;
    // Stage 3: local coordinates
    logic signed [LOC_W-1:0]  r_loc_i, r_loc_j;
    logic        [HALF_W-1:0] r3_radius;

    logic signed [SUM_W-1:0]  n_sum_i, n_sum_j;

    always_comb begin
        n_sum_i = SUM_W'(r_p_xax) + SUM_W'(r_p_yay) + RND_SUM;
        n_sum_j = SUM_W'(r_p_yax) - SUM_W'(r_p_xay) + RND_SUM;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_dx      <= DIFF_W'(i_point_x) - DIFF_W'(i_cfg.center_x);
            r_dy      <= DIFF_W'(i_point_y) - DIFF_W'(i_cfg.center_y);
            r1_radius <= i_radius;
        end
        if (i_adv[1]) begin
            r_p_xax   <= PROD_W'(r_dx) * PROD_W'(i_cfg.axis_x);
            r_p_yay   <= PROD_W'(r_dy) * PROD_W'(i_cfg.axis_y);
            r_p_yax   <= PROD_W'(r_dy) * PROD_W'(i_cfg.axis_x);
            r_p_xay   <= PROD_W'(r_dx) * PROD_W'(i_cfg.axis_y);
            r2_radius <= r1_radius;
        end
        if (i_adv[2]) begin
            // round half up, drop the axis fraction bits
            r_loc_i   <= n_sum_i[SUM_W-1:AXIS_FRAC];
            r_loc_j   <= n_sum_j[SUM_W-1:AXIS_FRAC];
            r3_radius <= r2_radius;
        end
    end

    assign o_loc_i  = r_loc_i;
    assign o_loc_j  = r_loc_j;
    assign o_radius = r3_radius;

endmodule

`default_nettype wire

### rtl/core/obq_clamp.sv
`default_nettype none

module obq_clamp
    import obq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_stage_en               i_adv,
    input  wire t_cfg                    i_cfg,
    input  wire logic signed [LOC_W-1:0] i_loc_i,
    input  wire logic signed [LOC_W-1:0] i_loc_j,
    input  wire logic        [HALF_W-1:0] i_radius,
    output t_clamp                       o_clamp
);

    t_clamp r_clamp;

    logic signed [LOC_W-1:0]  w_h_i, w_h_j, w_c_i, w_c_j;
    logic signed [ERRD_W-1:0] w_d_i, w_d_j;
    logic        [ERRD_W-1:0] w_m_i, w_m_j;

    always_comb begin
        w_h_i = $signed({{(LOC_W - HALF_W){1'b0}}, i_cfg.half_x});
        w_h_j = $signed({{(LOC_W - HALF_W){1'b0}}, i_cfg.half_y});

        if (i_loc_i > w_h_i)       w_c_i = w_h_i;
        else if (i_loc_i < -w_h_i) w_c_i = -w_h_i;
        else                       w_c_i = i_loc_i;

        if (i_loc_j > w_h_j)       w_c_j = w_h_j;
        else if (i_loc_j < -w_h_j) w_c_j = -w_h_j;
        else                       w_c_j = i_loc_j;

        w_d_i = ERRD_W'(w_c_i) - ERRD_W'(i_loc_i);
        w_d_j = ERRD_W'(w_c_j) - ERRD_W'(i_loc_j);
        w_m_i = w_d_i[ERRD_W-1] ? ERRD_W'(-w_d_i) : ERRD_W'(w_d_i);
        w_m_j = w_d_j[ERRD_W-1] ? ERRD_W'(-w_d_j) : ERRD_W'(w_d_j);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r_clamp.clamp_i <= w_c_i[COORD_W-1:0];
            r_clamp.clamp_j <= w_c_j[COORD_W-1:0];
            r_clamp.err_i   <= w_m_i[HALF_W-1:0];
            r_clamp.err_j   <= w_m_j[HALF_W-1:0];
            r_clamp.radius  <= i_radius;
            r_clamp.in_box  <= (i_loc_i < w_h_i) && (i_loc_i > -w_h_i)
                            && (i_loc_j < w_h_j) && (i_loc_j > -w_h_j);
            // any error at or beyond 2^31 can never fall inside the radius
            r_clamp.far     <= (|w_m_i[ERRD_W-1:HALF_W]) || (|w_m_j[ERRD_W-1:HALF_W]);
        end
    end

    assign o_clamp = r_clamp;

endmodule

`default_nettype wire

### rtl/core/obq_resolve.sv
`default_nettype none

module obq_resolve
    import obq_pkg::*;
(
    input  wire logic          i_clk,
    input  wire t_stage_en     i_adv,
    input  wire t_cfg          i_cfg,
    input  wire t_clamp        i_clamp,
    output logic               o_inside,
    output logic [COORD_W-1:0] o_closest_x,
    output logic [COORD_W-1:0] o_closest_y
);

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    // Stage 5: squares and world products
    logic        [SQ_W-1:0]    r_sq_i, r_sq_j, r_sq_r;
    logic signed [WPROD_W-1:0] r_w_iax, r_w_jay, r_w_iay, r_w_jax;
    logic                      r5_in_box, r5_far;
    // Stage 6: distance verdict and rounded world offsets
    logic signed [WLOC_W-1:0]  r_wl_x, r_wl_y;
    logic                      r6_inside;
    // Stage 7: output register
    logic        [COORD_W-1:0] r_cx, r_cy;
    logic                      r7_inside;

    logic        [D2_W-1:0]    n_d2;
    logic signed [WSUM_W-1:0]  n_ws_x, n_ws_y;
    logic signed [WORLD_W-1:0] n_wd_x, n_wd_y;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [WORLD_W-1:0] v);
        logic hi_same;
        hi_same = (&v[WORLD_W-1:COORD_W-1]) || !(|v[WORLD_W-1:COORD_W-1]);
        if (hi_same)              return v[COORD_W-1:0];
        else if (v[WORLD_W-1])    return SAT_MIN;
        else                      return SAT_MAX;
    endfunction

    always_comb begin
        n_d2   = D2_W'(r_sq_i) + D2_W'(r_sq_j);
        n_ws_x = WSUM_W'(r_w_iax) - WSUM_W'(r_w_jay) + RND_WSUM;
        n_ws_y = WSUM_W'(r_w_iay) + WSUM_W'(r_w_jax) + RND_WSUM;
        n_wd_x = WORLD_W'(i_cfg.center_x) + WORLD_W'(r_wl_x);
        n_wd_y = WORLD_W'(i_cfg.center_y) + WORLD_W'(r_wl_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[4]) begin
            r_sq_i    <= SQ_W'(i_clamp.err_i) * SQ_W'(i_clamp.err_i);
            r_sq_j    <= SQ_W'(i_clamp.err_j) * SQ_W'(i_clamp.err_j);
            r_sq_r    <= SQ_W'(i_clamp.radius) * SQ_W'(i_clamp.radius);
            r_w_iax   <= WPROD_W'(i_clamp.clamp_i) * WPROD_W'(i_cfg.axis_x);
            r_w_jay   <= WPROD_W'(i_clamp.clamp_j) * WPROD_W'(i_cfg.axis_y);
            r_w_iay   <= WPROD_W'(i_clamp.clamp_i) * WPROD_W'(i_cfg.axis_y);
            r_w_jax   <= WPROD_W'(i_clamp.clamp_j) * WPROD_W'(i_cfg.axis_x);
            r5_in_box <= i_clamp.in_box;
            r5_far    <= i_clamp.far;
        end
        if (i_adv[5]) begin
            r6_inside <= r5_in_box || (!r5_far && (n_d2 < D2_W'(r_sq_r)));
            r_wl_x    <= n_ws_x[WSUM_W-1:AXIS_FRAC];
            r_wl_y    <= n_ws_y[WSUM_W-1:AXIS_FRAC];
        end
        if (i_adv[6]) begin
            r7_inside <= r6_inside;
            r_cx      <= sat_coord(n_wd_x);
            r_cy      <= sat_coord(n_wd_y);
        end
    end

    assign o_inside    = r7_inside;
    assign o_closest_x = r_cx;
    assign o_closest_y = r_cy;

endmodule

`default_nettype wire

### rtl/core/oriented_box_point_query_unit.sv
// Throughput: one query per cycle unless the result side stalls;
// each of the seven stages holds at most one item.
// Stalls back up stage by stage, so empty stages keep taking input while a result waits.
// Reset (synchronous, active low) empties the pipeline and loads the box registers:
// center 0, half extents 0, right axis (1.0, 0).
`default_nettype none

module oriented_box_point_query_unit
    import obq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [COORD_W-1:0]   i_cfg_wdata,
    // query stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [95:0]          i_s_axis_tdata,  // point_x, point_y, query_radius, pad
    // result stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [63:0]               o_m_axis_tdata,  // closest_x, closest_y
    output logic [0:0]                o_m_axis_tuser   // inside_res
);

    t_cfg       w_cfg;
    t_clamp     w_clamp;
    t_stage_en  r_vld;
    t_stage_en  w_rdy;

    logic signed [LOC_W-1:0]   w_loc_i, w_loc_j;
    logic        [HALF_W-1:0]  w_radius;
    logic                      w_inside;
    logic        [COORD_W-1:0] w_cx, w_cy;

    // A stage loads when it is empty or its successor loads this cycle.
    always_comb begin
        w_rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || i_m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Advance valid bits alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    obq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Stages 1-3: offset, rotate into box frame, round.
    obq_proj u_proj (
        .i_clk     (i_clk),
        .i_adv     (w_rdy),
        .i_cfg     (w_cfg),
        .i_point_x ($signed(i_s_axis_tdata[31:0])),
        .i_point_y ($signed(i_s_axis_tdata[63:32])),
        .i_radius  (i_s_axis_tdata[94:64]),
        .o_loc_i   (w_loc_i),
        .o_loc_j   (w_loc_j),
        .o_radius  (w_radius)
    );

    // Stage 4: clamp to the extents, strict box test, clamp error.
    obq_clamp u_clamp (
        .i_clk    (i_clk),
        .i_adv    (w_rdy),
        .i_cfg    (w_cfg),
        .i_loc_i  (w_loc_i),
        .i_loc_j  (w_loc_j),
        .i_radius (w_radius),
        .o_clamp  (w_clamp)
    );

    // Stages 5-7: radius test and clamped point back to world, saturated.
    obq_resolve u_resolve (
        .i_clk       (i_clk),
        .i_adv       (w_rdy),
        .i_cfg       (w_cfg),
        .i_clamp     (w_clamp),
        .o_inside    (w_inside),
        .o_closest_x (w_cx),
        .o_closest_y (w_cy)
    );

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[NSTAGE-1];
    assign o_m_axis_tdata  = {w_cy, w_cx};
    assign o_m_axis_tuser  = w_inside;

    // Input can only be refused when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld))
        else $error("input refused while a pipeline stage is empty");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // An item in stage 1 moves on when stage 2 loads.
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && w_rdy[1]) |=> r_vld[1])
        else $error("item lost between stage 1 and stage 2");

    // A result waiting at the output is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTAGE-1] && !i_m_axis_tready) |=> (r_vld[NSTAGE-1] && $stable(w_cx)
            && $stable(w_cy) && $stable(w_inside)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
